[rtl/bia_pkg.sv]
package bia_pkg;

   // Field widths of the request and response transfers
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 11;
   localparam int STATUS_W = 2;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Request actions
   localparam action_type ACT_ALLOC   = 2'd0;
   localparam action_type ACT_RELEASE = 2'd1;
   localparam action_type ACT_QUERY   = 2'd2;
   localparam action_type ACT_RESTORE = 2'd3;

   // Response status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_USED  = 2'd3;

endpackage

[rtl/bia_req_if.sv]
interface bia_req_if import bia_pkg::*;;

   logic       valid;
   logic       ready;
   action_type action;
   index_type  requested_index;

   modport source (output valid, output action, output requested_index, input ready);
   modport sink   (input valid, input action, input requested_index, output ready);

endinterface

[rtl/bia_rsp_if.sv]
interface bia_rsp_if import bia_pkg::*;;

   logic       valid;
   logic       ready;
   index_type  granted_index;
   logic       index_busy;
   status_type status;

   modport source (output valid, output granted_index, output index_busy, output status,
                   input ready);
   modport sink   (input valid, input granted_index, input index_busy, input status,
                   output ready);

endinterface

[rtl/bia_ram.sv]
module bia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bia_first_zero.sv]
module bia_first_zero #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]         word,
   output logic [WORD_BITS-1:0]         onehot,
   output logic [$clog2(WORD_BITS)-1:0] pos,
   output logic                         found
);

   localparam int BIT_W = $clog2(WORD_BITS);

   // Lowest clear bit as a one-hot mask: zero when the word is full
   assign onehot = ~word & (word + WORD_BITS'(1));
   assign found  = |onehot;

   // Encode the one-hot mask; each bit contributes independently
   always_comb begin
      pos = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         pos = pos | (onehot[b] ? BIT_W'(b) : BIT_W'(0));
      end
   end

endmodule

[rtl/bitmap_index_allocator_unit.sv]
// Bitmap index allocator: hands out one-based indices 1..MAP_WORDS*WORD_BITS.
// Request channel (req_ch): action and requested_index. Allocate takes the
// lowest free index; release frees an index; query reports whether an index
// is in use; restore marks a given free index. Response channel (rsp_ch):
// granted_index, index_busy and status, exactly one response per request.
// The map lives in a single-port-read RAM, one word per row. Allocate reads
// one word per cycle through a one-stage read pipeline and finds the lowest
// clear bit with an add-and-mask. Release, query and restore locate the
// word by one subtract-and-compare per cycle, then do a read-modify-write;
// an index out of range skips both and gets ST_RANGE. One request is in
// flight at a time. After reset the block clears the map, one word per
// cycle, and holds req_ch.ready low until the clear is done. The response
// sits in an output register; a new request may be taken while it waits,
// but the next response is held back until the receiver has taken the
// previous one.
module bitmap_index_allocator_unit import bia_pkg::*; #(
   parameter int MAP_WORDS = 32,
   parameter int WORD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   bia_req_if.sink   req_ch,
   bia_rsp_if.source rsp_ch
);

   localparam int CAPACITY = MAP_WORDS * WORD_BITS;
   localparam int ADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W    = $clog2(WORD_BITS);
   localparam int CAP_W    = $clog2(CAPACITY + 1);
   localparam int SUM_W    = (CAP_W + 1 > INDEX_W) ? CAP_W + 1 : INDEX_W;
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

   // Sequencer states
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOCATE = 3'd2;
   localparam logic [2:0] S_MODIFY = 3'd3;
   localparam logic [2:0] S_ALLOC  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] word_ff, word_in;
   logic [ADDR_W-1:0] chk_word_ff, chk_word_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [CAP_W-1:0]  base_ff, base_in;
   logic [CAP_W-1:0]  off_ff, off_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   action_type        act_ff, act_in;
   index_type         res_granted_ff, res_granted_in;
   logic              res_busy_ff, res_busy_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   index_type         rsp_granted_ff, rsp_granted_in;
   logic              rsp_busy_ff, rsp_busy_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic                 req_xfer;
   logic                 idx_ok;
   logic                 rsp_load;
   logic                 ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;
   logic [WORD_BITS-1:0] fz_onehot;
   logic [BIT_W-1:0]     fz_pos;
   logic                 fz_found;
   logic [WORD_BITS-1:0] bit_mask;
   logic [SUM_W-1:0]     grant_sum;

   bia_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   bia_first_zero #(
      .WORD_BITS(WORD_BITS)
   ) u_first_zero (
      .word  (ram_rd_data),
      .onehot(fz_onehot),
      .pos   (fz_pos),
      .found (fz_found)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign idx_ok       = (req_ch.requested_index != '0) &&
                         (32'(req_ch.requested_index) <= 32'(CAPACITY));

   assign bit_mask  = WORD_BITS'(1) << bit_ff;
   assign grant_sum = SUM_W'(base_ff) + SUM_W'(fz_pos) + SUM_W'(1);

   // Response register loads once the previous response has been taken
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      word_in        = word_ff;
      chk_word_in    = chk_word_ff;
      chk_valid_in   = chk_valid_ff;
      base_in        = base_ff;
      off_in         = off_ff;
      bit_in         = bit_ff;
      act_in         = act_ff;
      res_granted_in = res_granted_ff;
      res_busy_in    = res_busy_ff;
      res_status_in  = res_status_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = word_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = word_ff;

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en = 1'b1;
            if (word_ff == LAST_WORD) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + ADDR_W'(1);
            end
         end

         S_IDLE: begin
            if (req_xfer) begin
               act_in         = req_ch.action;
               word_in        = '0;
               base_in        = '0;
               chk_valid_in   = 1'b0;
               off_in         = CAP_W'(req_ch.requested_index - INDEX_W'(1));
               res_granted_in = '0;
               res_busy_in    = 1'b0;
               res_status_in  = ST_OK;
               if (req_ch.action == ACT_ALLOC) begin
                  state_in = S_ALLOC;
               end else if (!idx_ok) begin
                  res_status_in = ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_LOCATE;
               end
            end
         end

         // Peel whole words off the offset until the bit falls in this word
         S_LOCATE: begin
            if (off_ff < CAP_W'(WORD_BITS)) begin
               bit_in    = off_ff[BIT_W-1:0];
               ram_rd_en = 1'b1;
               state_in  = S_MODIFY;
            end else begin
               off_in  = off_ff - CAP_W'(WORD_BITS);
               word_in = word_ff + ADDR_W'(1);
            end
         end

         // Read-modify-write of the located word
         S_MODIFY: begin
            ram_wr_addr = word_ff;
            case (act_ff)
               ACT_RELEASE: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data & ~bit_mask;
               end
               ACT_QUERY: begin
                  res_busy_in = |(ram_rd_data & bit_mask);
               end
               ACT_RESTORE: begin
                  if (|(ram_rd_data & bit_mask)) begin
                     res_status_in = ST_USED;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = ram_rd_data | bit_mask;
                  end
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end

         // Read word_ff while checking the word read last cycle
         S_ALLOC: begin
            ram_rd_en = 1'b1;
            if (chk_valid_ff && fz_found) begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = chk_word_ff;
               ram_wr_data    = ram_rd_data | fz_onehot;
               res_granted_in = grant_sum[INDEX_W-1:0];
               state_in       = S_DONE;
            end else if (chk_valid_ff && (chk_word_ff == LAST_WORD)) begin
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               chk_valid_in = 1'b1;
               chk_word_in  = word_ff;
               word_in      = (word_ff == LAST_WORD) ? word_ff : word_ff + ADDR_W'(1);
               if (chk_valid_ff) begin
                  base_in = base_ff + CAP_W'(WORD_BITS);
               end
            end
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_granted_in = rsp_granted_ff;
      rsp_busy_in    = rsp_busy_ff;
      rsp_status_in  = rsp_status_ff;
      if (rsp_load) begin
         rsp_granted_in = res_granted_ff;
         rsp_busy_in    = res_busy_ff;
         rsp_status_in  = res_status_ff;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      chk_word_ff    <= chk_word_in;
      base_ff        <= base_in;
      off_ff         <= off_in;
      bit_ff         <= bit_in;
      act_ff         <= act_in;
      res_granted_ff <= res_granted_in;
      res_busy_ff    <= res_busy_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_busy_ff    <= rsp_busy_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.granted_index = rsp_granted_ff;
   assign rsp_ch.index_busy    = rsp_busy_ff;
   assign rsp_ch.status        = rsp_status_ff;

   // The map clear keeps requests out right after reset
   a_clear_after_reset: assert property (
      @(posedge clock) $fell(reset) |-> !req_ch.ready
   ) else $error("request taken during map clear");

   // A new response only follows the final sequencer step
   a_rsp_from_done: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(state_ff) == S_DONE
   ) else $error("response raised outside the final step");

   // A granted index always comes with an ok status
   a_grant_ok: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.granted_index != '0)) |-> rsp_ch.status == ST_OK
   ) else $error("granted index with error status");

   // Busy is reported only for a good status
   a_busy_ok: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.index_busy) |->
         (rsp_ch.status == ST_OK) && (rsp_ch.granted_index == '0)
   ) else $error("busy flag on a non-query response");

endmodule
